### hw/rtl/nqbs_pkg.sv
// ----------------------------------------------------------------------------
// N-queens search package
// Shared constants, register indexes and controller/datapath handshake types.
// ----------------------------------------------------------------------------
package nqbs_pkg;

  localparam int DEF_MAX_QUEENS = 16;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;
  localparam int BOARD_W    = 5;
  localparam int BUDGET_W   = 32;

  localparam logic [CFG_IDX_W-1:0] REG_BOARD_SIZE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_BUDGET = 1'd1;

  localparam logic [BOARD_W-1:0]  BOARD_RST  = 5'd8;
  localparam logic [BUDGET_W-1:0] BUDGET_RST = 32'd1000000;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 16;
  localparam int COL_OUT_W   = 4;
  localparam int ROW_OUT_W   = 4;
  localparam int DEPTH_OUT_W = 5;

  typedef struct packed {
    logic init;
    logic step;
    logic finish;
    logic emit_adv;
  } dp_cmd_t;

  typedef struct packed {
    logic at_full;
    logic budget_hit;
    logic exhaust;
    logic emit_last;
  } dp_sts_t;

endpackage

### hw/rtl/nqbs_ctrl.sv
// ----------------------------------------------------------------------------
// N-queens search controller
// Sequences request intake, the backtracking steps and result delivery.
// ----------------------------------------------------------------------------
module nqbs_ctrl
  import nqbs_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  input  logic    start_req,
  output logic    in_tready,
  output logic    out_tvalid,
  input  logic    out_tready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_EMIT
  } state_t;

  state_t state_r;
  logic   in_tready_r;
  logic   out_tvalid_r;

  assign in_tready  = in_tready_r;
  assign out_tvalid = out_tvalid_r;

  always_comb begin
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        cmd.init = in_tvalid & start_req;
      end
      S_SEARCH: begin
        if (sts.at_full || sts.budget_hit) begin
          cmd.finish = 1'b1;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_EMIT: begin
        cmd.emit_adv = out_tready;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      in_tready_r  <= 1'b1;
      out_tvalid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid && start_req) begin
            state_r     <= S_SEARCH;
            in_tready_r <= 1'b0;
          end
        end
        S_SEARCH: begin
          if (sts.at_full || sts.budget_hit || sts.exhaust) begin
            state_r      <= S_EMIT;
            out_tvalid_r <= 1'b1;
          end
        end
        S_EMIT: begin
          if (out_tready && sts.emit_last) begin
            state_r      <= S_IDLE;
            out_tvalid_r <= 1'b0;
            in_tready_r  <= 1'b1;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### hw/rtl/nqbs_dp.sv
// ----------------------------------------------------------------------------
// N-queens search datapath
// Holds configuration, the working and best placements and the step counter.
// ----------------------------------------------------------------------------
module nqbs_dp
  import nqbs_pkg::*;
#(
  parameter int MAX_QUEENS = DEF_MAX_QUEENS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  dp_cmd_t                cmd,
  output dp_sts_t                sts,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast
);

  localparam int COL_W = $clog2(MAX_QUEENS);
  localparam int CNT_W = $clog2(MAX_QUEENS + 1);
  localparam int ROW_W = COL_W;

  logic [BOARD_W-1:0]  board_size_r;
  logic [BUDGET_W-1:0] step_budget_r;

  logic [ROW_W-1:0] rows_r      [MAX_QUEENS];
  logic [ROW_W-1:0] rows_upd    [MAX_QUEENS];
  logic [ROW_W-1:0] best_rows_r [MAX_QUEENS];
  logic [MAX_QUEENS-1:0] valid_r;
  logic [CNT_W-1:0]    active_r;
  logic [CNT_W-1:0]    best_depth_r;
  logic [BUDGET_W-1:0] steps_r;
  logic                solved_r;
  logic                ran_out_r;
  logic [COL_W-1:0]    k_r;

  logic [CNT_W-1:0] n;
  logic [COL_W-1:0] col;
  logic [CNT_W-1:0] r_try;
  logic [CNT_W-1:0] active_inc;
  logic             over;
  logic             fits;
  logic [MAX_QUEENS-1:0] clash;
  logic [CNT_W-1:0] lane_other [MAX_QUEENS];
  logic [CNT_W-1:0] lane_diff  [MAX_QUEENS];
  logic [CNT_W-1:0] lane_dist  [MAX_QUEENS];

  logic             placed;
  logic [ROW_OUT_W-1:0] row_out;

  always_comb begin
    if (board_size_r == '0) begin
      n = CNT_W'(1);
    end else if (32'(board_size_r) > MAX_QUEENS) begin
      n = CNT_W'(MAX_QUEENS);
    end else begin
      n = CNT_W'(board_size_r);
    end
  end

  assign col        = active_r[COL_W-1:0];
  assign r_try      = valid_r[col] ? CNT_W'(rows_r[col]) + CNT_W'(1) : '0;
  assign over       = (r_try >= n);
  assign active_inc = active_r + CNT_W'(1);

  always_comb begin
    for (int i = 0; i < MAX_QUEENS; i++) begin
      lane_other[i] = CNT_W'(rows_r[i]);
      lane_dist[i]  = active_r - CNT_W'(i);
      lane_diff[i]  = (lane_other[i] > r_try) ? lane_other[i] - r_try
                                              : r_try - lane_other[i];
      clash[i]      = (CNT_W'(i) < active_r) &&
                      ((lane_diff[i] == '0) || (lane_diff[i] == lane_dist[i]));
    end
  end

  assign fits = ~|clash;

  always_comb begin
    rows_upd      = rows_r;
    rows_upd[col] = r_try[ROW_W-1:0];
  end

  assign sts.at_full    = (active_r >= n);
  assign sts.budget_hit = (steps_r >= step_budget_r);
  assign sts.exhaust    = over && (active_r == '0);
  assign sts.emit_last  = ((CNT_W'(k_r) + CNT_W'(1)) == n);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      board_size_r  <= BOARD_RST;
      step_budget_r <= BUDGET_RST;
      valid_r       <= '0;
      active_r      <= '0;
      best_depth_r  <= '0;
      steps_r       <= '0;
      solved_r      <= 1'b0;
      ran_out_r     <= 1'b0;
      k_r           <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_BOARD_SIZE:  board_size_r  <= cfg_data[BOARD_W-1:0];
          REG_STEP_BUDGET: step_budget_r <= cfg_data[BUDGET_W-1:0];
          default: ;
        endcase
      end
      if (cmd.init) begin
        valid_r      <= '0;
        active_r     <= '0;
        best_depth_r <= '0;
        steps_r      <= '0;
        solved_r     <= 1'b0;
        ran_out_r    <= 1'b0;
        k_r          <= '0;
      end
      if (cmd.step) begin
        steps_r <= steps_r + BUDGET_W'(1);
        if (over) begin
          valid_r[col] <= 1'b0;
          if (active_r != '0) begin
            active_r <= active_r - CNT_W'(1);
          end
        end else begin
          valid_r[col] <= 1'b1;
          if (fits) begin
            active_r <= active_inc;
            if (active_inc > best_depth_r) begin
              best_depth_r <= active_inc;
            end
          end
        end
      end
      if (cmd.finish) begin
        solved_r  <= sts.at_full;
        ran_out_r <= ~sts.at_full & sts.budget_hit;
      end
      if (cmd.emit_adv) begin
        k_r <= k_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step && !over) begin
      rows_r[col] <= r_try[ROW_W-1:0];
      if (fits && (active_inc > best_depth_r)) begin
        best_rows_r <= rows_upd;
      end
    end
  end

  assign placed  = (CNT_W'(k_r) < best_depth_r);
  assign row_out = placed ? ROW_OUT_W'(best_rows_r[k_r]) : '0;

  assign out_tdata = {ran_out_r,
                      solved_r,
                      DEPTH_OUT_W'(best_depth_r),
                      placed,
                      row_out,
                      COL_OUT_W'(k_r)};
  assign out_tlast = sts.emit_last;

endmodule

### hw/rtl/n_queens_backtrack_search.sv
// ----------------------------------------------------------------------------
// N-queens backtracking search
// A request with start_req set runs one column-by-column backtracking search
// and returns the deepest conflict-free placement, one result per column.
//
// Channels: cfg_* writes board_size (index 0) or step_budget (index 1) and is
// always ready; write only while no request is in progress. in_* takes a
// request when idle; a request with start_req clear is taken and dropped.
// out_* returns n results (n = board_size clamped to 1..MAX_QUEENS), column
// 0 first, out_tlast on column n-1.
// Search: each step tries a row or backtracks, and a search makes at most
// step_budget steps; then n results follow, one per cycle while out_tready
// is high. The next request is taken the cycle after the last result. The
// step loop makes one step per cycle, checking the new row against all
// earlier columns at once.
// Reset: registers return to board_size 8, step_budget 1000000, idle.
// A stalled receiver holds the current result until it is taken.
// ----------------------------------------------------------------------------
module n_queens_backtrack_search
  import nqbs_pkg::*;
#(
  parameter int MAX_QUEENS = DEF_MAX_QUEENS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [0] start_req, [7:1] zero
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [3:0] column, [7:4] row, [8] row_placed, [13:9] queens_placed,
  // [14] solved, [15] budget_ran_out
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready = 1'b1;

  nqbs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .start_req  (in_tdata[0]),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  nqbs_dp #(
    .MAX_QUEENS (MAX_QUEENS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

endmodule

### bench/tb.sv
// ----------------------------------------------------------------------------
// N-queens backtracking search testbench
// Drives search requests and register writes into n_queens_backtrack_search
// and predicts every placement result with a behavioural copy of the search.
// Directed tests cover the default registers, dropped requests, board size
// and step budget extremes, and a long output hold-off. Random searches then
// run under four mixes of sender idling and receiver stalls.
// ----------------------------------------------------------------------------
module tb;
  import nqbs_pkg::*;

  localparam int QMAX            = DEF_MAX_QUEENS;
  localparam int CYCLE_LIMIT     = 3000000;
  localparam int HOLD_CYCLES     = 400;
  localparam int SETTLE_CYCLES   = 20;
  localparam int RANDOM_REQUESTS = 72;
  localparam int REPORT_LIMIT    = 60;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  // {tlast, tdata}: column, row, row_placed, queens_placed, solved, budget_ran_out, last
  typedef struct packed {
    logic       last;
    logic       ran_out;
    logic       solved;
    logic [4:0] queens;
    logic       placed;
    logic [3:0] row;
    logic [3:0] column;
  } qresult_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_data   = '0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;   // [0] start_req, [7:1] zero
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // [3:0] column, [7:4] row, [8] row_placed, [13:9] queens_placed,
  // [14] solved, [15] budget_ran_out
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;

  logic [BOARD_W-1:0]  board_cfg  = BOARD_RST;
  logic [BUDGET_W-1:0] budget_cfg = BUDGET_RST;

  qresult_t    placement_q[$];
  int unsigned err_count      = 0;
  int unsigned request_count  = 0;
  int unsigned result_count   = 0;
  int unsigned cfg_count      = 0;
  int unsigned cycle_count    = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_active    = 1'b0;
  event        hold_trigger;

  n_queens_backtrack_search DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // hold the receiver off for a long stretch
  always begin
    @(hold_trigger);
    hold_active = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_active = 1'b0;
  end

  always @(negedge clk)
    out_tready <= !hold_active && ($urandom_range(99) >= recv_stall_pct);

  function automatic string show_result(input qresult_t r);
    return $sformatf("col=%0d row=%0d placed=%0b queens=%0d solved=%0b ran_out=%0b last=%0b",
                     r.column, r.row, r.placed, r.queens, r.solved, r.ran_out, r.last);
  endfunction

  // column-by-column backtracking search on the shadow registers
  function automatic void predict_search();
    int unsigned n, col, r, depth, steps, gap, diff, i;
    int unsigned cur_row [QMAX];
    bit          cur_set [QMAX];
    int unsigned best_row [QMAX];
    bit          solved, ran_out, fits;
    qresult_t    res;
    n = board_cfg;
    if (n < 1) n = 1;
    if (n > QMAX) n = QMAX;
    for (i = 0; i < QMAX; i++) begin
      cur_row[i]  = 0;
      cur_set[i]  = 1'b0;
      best_row[i] = 0;
    end
    col     = 0;
    depth   = 0;
    steps   = 0;
    solved  = 1'b0;
    ran_out = 1'b0;
    while (1) begin
      if (col >= n) begin
        solved = 1'b1;
        break;
      end
      if (steps >= budget_cfg) begin
        ran_out = 1'b1;
        break;
      end
      steps++;
      r = cur_set[col] ? cur_row[col] + 1 : 0;
      if (r >= n) begin
        cur_set[col] = 1'b0;
        cur_row[col] = 0;
        if (col == 0) break;
        col--;
      end else begin
        cur_row[col] = r;
        cur_set[col] = 1'b1;
        fits = 1'b1;
        for (i = 0; i < col; i++) begin
          gap  = col - i;
          diff = (cur_row[i] > r) ? cur_row[i] - r : r - cur_row[i];
          if (diff == 0 || diff == gap) fits = 1'b0;
        end
        if (fits) begin
          col++;
          if (col > depth) begin
            depth    = col;
            best_row = cur_row;
          end
        end
      end
    end
    for (i = 0; i < n; i++) begin
      res.column  = i[3:0];
      res.placed  = (i < depth);
      res.row     = res.placed ? best_row[i][3:0] : 4'd0;
      res.queens  = depth[4:0];
      res.solved  = solved;
      res.ran_out = ran_out;
      res.last    = (i + 1 == n);
      placement_q.push_back(res);
    end
  endfunction

  always @(posedge clk) begin : check_results
    qresult_t seen, want;
    if (rst_n && out_tvalid && out_tready) begin
      seen = {out_tlast, out_tdata};
      result_count++;
      if (placement_q.size() == 0) begin
        err_count++;
        if (err_count <= REPORT_LIMIT)
          $display("%0t: result with none expected, expected nothing, got %s",
                   $time, show_result(seen));
      end else begin
        want = placement_q.pop_front();
        if (seen !== want) begin
          err_count++;
          if (err_count <= REPORT_LIMIT)
            $display("%0t: result mismatch, expected %s, got %s",
                     $time, show_result(want), show_result(seen));
        end
      end
    end
  end

  task automatic set_idle(input idle_mode_t mode);
    case (mode)
      IDLE_SENDER: begin
        send_idle_pct  = 68;
        recv_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        send_idle_pct  = 0;
        recv_stall_pct = 68;
      end
      IDLE_BOTH: begin
        send_idle_pct  = 8;
        recv_stall_pct = 8;
      end
      default: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
    endcase
  endtask

  task automatic send_request(input logic start);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W-1){1'b0}}, start};
    do @(posedge clk); while (!in_tready);
    if (start) begin
      request_count++;
      predict_search();
    end
  endtask

  // drop the request line and let all pending results drain
  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (placement_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_BOARD_SIZE) board_cfg = value[BOARD_W-1:0];
    else if (idx == REG_STEP_BUDGET) budget_cfg = value;
    cfg_count++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] board,
                           input logic [CFG_DATA_W-1:0] budget);
    settle();
    write_reg(REG_BOARD_SIZE, board);
    write_reg(REG_STEP_BUDGET, budget);
  endtask

  task automatic test_reset_defaults();
    set_idle(IDLE_NONE);
    send_request(1'b1);
  endtask

  task automatic test_start_zero();
    set_idle(IDLE_NONE);
    send_request(1'b0);
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b1);
  endtask

  task automatic test_board_limits();
    set_idle(IDLE_RECEIVER);
    configure(32'd0, 32'd1000);
    send_request(1'b1);
    configure(32'd1, 32'd1000);
    send_request(1'b1);
    configure(32'd2, 32'hFFFF_FFFF);
    send_request(1'b1);
    configure(32'd3, 32'hFFFF_FFFF);
    send_request(1'b1);
    configure(32'd4, 32'd1000);
    send_request(1'b1);
    configure(32'd16, 32'd2500);
    send_request(1'b1);
    configure(32'd17, 32'd1200);
    send_request(1'b1);
    configure(32'd31, 32'd1500);
    send_request(1'b1);
  endtask

  task automatic test_budget_limits();
    set_idle(IDLE_BOTH);
    configure(32'd8, 32'd0);
    send_request(1'b1);
    configure(32'd16, 32'd0);
    send_request(1'b1);
    configure(32'd5, 32'd1);
    send_request(1'b1);
    configure(32'd1, 32'd1);
    send_request(1'b1);
    configure(32'd6, 32'hFFFF_FFFF);
    send_request(1'b1);
  endtask

  // keep offering requests while the receiver is held off
  task automatic test_output_holdoff();
    set_idle(IDLE_NONE);
    configure(32'd6, 32'd5000);
    -> hold_trigger;
    repeat (4) send_request(1'b1);
    settle();
  endtask

  task automatic test_random_searches();
    int unsigned sent, phase, pick, board, eff;
    logic [CFG_DATA_W-1:0] board_word, budget;
    sent = 0;
    for (phase = 0; phase < 4; phase++) begin
      set_idle(idle_mode_t'(phase));
      while (sent < (phase + 1) * RANDOM_REQUESTS / 4) begin
        pick = $urandom_range(99);
        if (pick < 70) board = $urandom_range(1, 10);
        else if (pick < 85) board = $urandom_range(11, 16);
        else board = $urandom_range(0, 31);
        eff = (board < 1) ? 1 : (board > QMAX) ? QMAX : board;
        if (eff <= 12 && $urandom_range(3) == 0) budget = $urandom;
        else budget = $urandom_range(0, 3000);
        board_word = board;
        if ($urandom_range(3) == 0) board_word = ($urandom & ~32'h1F) | board;
        configure(board_word, budget);
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(9) == 0) begin
            send_request(1'b0);
          end else begin
            send_request(1'b1);
            sent++;
          end
        end
      end
    end
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_start_zero();
    test_board_limits();
    test_budget_limits();
    test_output_holdoff();
    test_random_searches();
    settle();
    $display("Ran %0d searches (board sizes 0..31, budgets 0..max, four idling mixes, hold-off)",
             request_count);
    $display("Checked %0d placement results after %0d register writes, %0d mismatches",
             result_count, cfg_count, err_count);
    if (err_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
